// File: rtl/vae_pkg.sv
// ----------------------------------------------------------------------------
// vae_pkg
// Shared types, codes and constants of the voice allocator with per-slot
// envelope: transaction structs, slot record layout, opcodes and limits.
// ----------------------------------------------------------------------------
package vae_pkg;

  // default number of voice slots
  localparam int SLOTS_DEF = 16;

  // configuration data width (widest register)
  localparam int CFG_W = 15;

  // opcodes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_ALL_OFF  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_PLACED   = 3'd0;
  localparam logic [2:0] KIND_OFF_DONE = 3'd1;
  localparam logic [2:0] KIND_LIVE     = 3'd2;
  localparam logic [2:0] KIND_NONE     = 3'd3;
  localparam logic [2:0] KIND_REJECT   = 3'd4;

  // envelope stages
  localparam logic [1:0] STG_IDLE     = 2'd0;
  localparam logic [1:0] STG_ATTACK   = 2'd1;
  localparam logic [1:0] STG_HELD     = 2'd2;
  localparam logic [1:0] STG_RELEASED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ATTACK_STEP = 2'd0;
  localparam logic [1:0] CFG_DAMP_COEF   = 2'd1;
  localparam logic [1:0] CFG_VOICE_LIM   = 2'd2;

  // configuration reset values
  localparam logic [14:0] ATTACK_STEP_RST = 15'd35;
  localparam logic [14:0] DAMP_COEF_RST   = 15'd32359;
  localparam logic [8:0]  VOICE_LIM_RST   = 9'd128;

  // playable note range and level limits
  localparam logic [6:0]  NOTE_LOW    = 7'd21;
  localparam logic [6:0]  NOTE_HIGH   = 7'd108;
  localparam logic [14:0] LEVEL_MAX   = 15'd32767;
  localparam logic [14:0] LEVEL_FLOOR = 15'd98;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [6:0]  velocity;
    logic [7:0]  voice;
    logic        is_sustained;
    logic        is_drum;
    logic [14:0] decay_coef;
    logic [31:0] end_time;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [6:0]  note_res;
    logic [7:0]  voice_res;
    logic [14:0] level;
    logic [6:0]  velocity_res;
    logic [4:0]  live_count;
    logic        last;
  } out_t;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic [6:0]  note;
    logic [7:0]  voice;
    logic [3:0]  channel;
    logic [6:0]  velocity;
    logic [1:0]  stage;
    logic        sustained;
    logic        drum;
    logic [14:0] level;
    logic [14:0] decay;
    logic [31:0] end_time;
  } rec_t;

endpackage

// File: rtl/vae_env_step.sv
// ----------------------------------------------------------------------------
// vae_env_step
// One tick of a slot envelope: attack ramp with saturation, held decay with
// end-time release, released decay, and the free test against the floor.
// ----------------------------------------------------------------------------
module vae_env_step (
  input  vae_pkg::rec_t rec_i,
  input  logic [14:0]   attack_step_i,
  input  logic [14:0]   damp_coef_i,
  input  logic [31:0]   now_time_i,
  output logic [14:0]   level_o,
  output logic [1:0]    stage_o,
  output logic          drop_o
);

  logic [15:0] sum;
  logic [14:0] coef;
  logic [29:0] prod;
  logic        do_mul;

  // Q15 decay product, truncated
  assign prod = {15'd0, rec_i.level} * {15'd0, coef};

  // advance the envelope by one tick
  always_comb begin
    sum     = {1'b0, rec_i.level} + {1'b0, attack_step_i};
    coef    = rec_i.decay;
    do_mul  = 1'b0;
    stage_o = rec_i.stage;
    level_o = rec_i.level;
    unique case (rec_i.stage)
      vae_pkg::STG_ATTACK: begin
        if (sum >= {1'b0, vae_pkg::LEVEL_MAX}) begin
          level_o = vae_pkg::LEVEL_MAX;
          stage_o = vae_pkg::STG_HELD;
        end else begin
          level_o = sum[14:0];
        end
      end
      vae_pkg::STG_HELD: begin
        do_mul = !rec_i.sustained;
        if (now_time_i >= rec_i.end_time && !rec_i.drum) begin
          stage_o = vae_pkg::STG_RELEASED;
        end
      end
      vae_pkg::STG_RELEASED: begin
        do_mul = 1'b1;
        coef   = rec_i.sustained ? rec_i.decay : damp_coef_i;
      end
      default: begin
        // stage zero keeps its level
      end
    endcase
    if (do_mul) begin
      level_o = prod[29:15];
    end
  end

  // free the slot once the level falls under the floor
  assign drop_o = level_o < vae_pkg::LEVEL_FLOOR;

endmodule

// File: rtl/voice_allocator_envelope.sv
// ----------------------------------------------------------------------------
// voice_allocator_envelope
// Polyphonic voice slot manager with a Q15 envelope per slot. Slot records
// live in a synchronous memory that each note on, note off and tick walks.
// ----------------------------------------------------------------------------
// Note on, note off and tick walk the slot memory one entry per cycle: the last
// result is on the outputs when busy clears, so a new such transaction is taken
// only after that. Tick reports of live slots come during the walk, each held
// until the next live one, the last closing the walk. Rejected notes and all
// notes off answer in the cycle after the accept with no busy time; the receiver
// cannot stall. Reset clears used bits and live count and loads config defaults.
module voice_allocator_envelope #(
  parameter int SLOTS = vae_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  vae_pkg::in_t              in_data,
  output logic                      out_valid,
  output vae_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [vae_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             proc_vld_r, proc_vld_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic             hit_r, hit_nxt;
  logic             free_r, free_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [14:0]      attack_r, attack_nxt;
  logic [14:0]      damper_r, damper_nxt;
  logic [8:0]       vcount_r, vcount_nxt;

  // payload
  vae_pkg::in_t     cmd_r, cmd_nxt;
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [14:0]      hit_level_r, hit_level_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] min_idx_r, min_idx_nxt;
  logic [14:0]      min_level_r, min_level_nxt;
  vae_pkg::out_t    pend_r, pend_nxt;
  vae_pkg::out_t    out_r, out_nxt;

  // slot memory
  vae_pkg::rec_t    mem [SLOTS];
  vae_pkg::rec_t    rd_rec_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  vae_pkg::rec_t    mem_wdata;

  // envelope step on the slot just read
  logic [14:0]      env_level;
  logic [1:0]       env_stage;
  logic             env_drop;

  logic             accept;
  logic [IDX_W-1:0] place_idx;
  logic             place_new;
  logic             proc_used;

  assign busy      = state_r != ST_IDLE;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_en     = state_r == ST_SCAN;
  assign rd_addr   = idx_r;
  assign proc_used = used_r[proc_idx_r];

  // pick the slot for a note on: matching slot, lowest free, lowest level
  assign place_idx = hit_r ? hit_idx_r : (free_r ? free_idx_r : min_idx_r);
  assign place_new = !hit_r && free_r;

  vae_env_step u_env_step (
    .rec_i         (rd_rec_r),
    .attack_step_i (attack_r),
    .damp_coef_i   (damper_r),
    .now_time_i    (cmd_r.now_time),
    .level_o       (env_level),
    .stage_o       (env_stage),
    .drop_o        (env_drop)
  );

  // sequencer, slot processing and result selection
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    used_nxt      = used_r;
    count_nxt     = count_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_level_nxt = hit_level_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    min_idx_nxt   = min_idx_r;
    min_level_nxt = min_level_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    attack_nxt    = attack_r;
    damper_nxt    = damper_r;
    vcount_nxt    = vcount_r;
    mem_we        = 1'b0;
    mem_waddr     = proc_idx_r;
    mem_wdata     = rd_rec_r;

    // take configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        vae_pkg::CFG_ATTACK_STEP: attack_nxt = cfg_wdata[14:0];
        vae_pkg::CFG_DAMP_COEF:   damper_nxt = cfg_wdata[14:0];
        vae_pkg::CFG_VOICE_LIM:   vcount_nxt = cfg_wdata[8:0];
        default: begin
          // index beyond the register list: drop
        end
      endcase
    end

    // process the slot read in the previous cycle
    if (proc_vld_r) begin
      unique case (cmd_r.op)
        vae_pkg::OP_TICK: begin
          if (proc_used) begin
            mem_we          = 1'b1;
            mem_wdata.level = env_level;
            mem_wdata.stage = env_stage;
            if (env_drop) begin
              used_nxt[proc_idx_r] = 1'b0;
              count_nxt            = count_r - CNT_W'(1);
            end else begin
              // release the held report, keep this one until the next
              if (pend_vld_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pend_r;
              end
              pend_vld_nxt          = 1'b1;
              pend_nxt.kind         = vae_pkg::KIND_LIVE;
              pend_nxt.slot         = 4'(proc_idx_r);
              pend_nxt.note_res     = rd_rec_r.note;
              pend_nxt.voice_res    = rd_rec_r.voice;
              pend_nxt.level        = env_level;
              pend_nxt.velocity_res = rd_rec_r.velocity;
              pend_nxt.live_count   = 5'd0;
              pend_nxt.last         = 1'b0;
            end
          end
        end
        vae_pkg::OP_NOTE_OFF: begin
          if (proc_used && rd_rec_r.note == cmd_r.note &&
              rd_rec_r.channel == cmd_r.channel &&
              rd_rec_r.stage == vae_pkg::STG_HELD) begin
            mem_we          = 1'b1;
            mem_wdata.stage = vae_pkg::STG_RELEASED;
          end
        end
        vae_pkg::OP_NOTE_ON: begin
          if (!hit_r && proc_used && rd_rec_r.note == cmd_r.note &&
              rd_rec_r.voice == cmd_r.voice &&
              rd_rec_r.channel == cmd_r.channel) begin
            hit_nxt       = 1'b1;
            hit_idx_nxt   = proc_idx_r;
            hit_level_nxt = rd_rec_r.level;
          end
          if (!free_r && !proc_used) begin
            free_nxt     = 1'b1;
            free_idx_nxt = proc_idx_r;
          end
          if (proc_idx_r == '0 || rd_rec_r.level < min_level_r) begin
            min_idx_nxt   = proc_idx_r;
            min_level_nxt = rd_rec_r.level;
          end
        end
        default: begin
          // all notes off never walks the memory
        end
      endcase
    end

    // sequencer
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data;
          if ({1'b0, in_data.voice} >= vcount_r) begin
            cmd_nxt.voice = 8'd0;
          end
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          pend_vld_nxt = 1'b0;
          unique case (in_data.op)
            vae_pkg::OP_NOTE_ON: begin
              if (in_data.note < vae_pkg::NOTE_LOW ||
                  in_data.note > vae_pkg::NOTE_HIGH) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
                out_nxt.kind       = vae_pkg::KIND_REJECT;
                out_nxt.note_res   = in_data.note;
                out_nxt.live_count = 5'(count_r);
                out_nxt.last       = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            vae_pkg::OP_NOTE_OFF,
            vae_pkg::OP_TICK: begin
              state_nxt = ST_SCAN;
            end
            vae_pkg::OP_ALL_OFF: begin
              used_nxt      = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              out_nxt.kind  = vae_pkg::KIND_NONE;
              out_nxt.last  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        proc_vld_nxt = 1'b1;
        proc_idx_nxt = idx_r;
        idx_nxt      = idx_r + IDX_W'(1);
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.last  = 1'b1;
        unique case (cmd_r.op)
          vae_pkg::OP_NOTE_ON: begin
            mem_we    = 1'b1;
            mem_waddr = place_idx;
            mem_wdata.note      = cmd_r.note;
            mem_wdata.voice     = cmd_r.voice;
            mem_wdata.channel   = cmd_r.channel;
            mem_wdata.velocity  = cmd_r.velocity;
            mem_wdata.stage     = vae_pkg::STG_ATTACK;
            mem_wdata.sustained = cmd_r.is_sustained;
            mem_wdata.drum      = cmd_r.is_drum;
            mem_wdata.level     = hit_r ? hit_level_r : 15'd0;
            mem_wdata.decay     = cmd_r.decay_coef;
            mem_wdata.end_time  = cmd_r.end_time;
            used_nxt[place_idx] = 1'b1;
            count_nxt           = count_r + CNT_W'(place_new);
            out_nxt.kind         = vae_pkg::KIND_PLACED;
            out_nxt.slot         = 4'(place_idx);
            out_nxt.note_res     = cmd_r.note;
            out_nxt.voice_res    = cmd_r.voice;
            out_nxt.level        = hit_r ? hit_level_r : 15'd0;
            out_nxt.velocity_res = cmd_r.velocity;
            out_nxt.live_count   = 5'(count_r + CNT_W'(place_new));
          end
          vae_pkg::OP_NOTE_OFF: begin
            out_nxt.kind       = vae_pkg::KIND_OFF_DONE;
            out_nxt.note_res   = cmd_r.note;
            out_nxt.live_count = 5'(count_r);
          end
          vae_pkg::OP_TICK: begin
            // close the walk with the held report or a nothing-live result
            if (pend_vld_r) begin
              out_nxt            = pend_r;
              out_nxt.live_count = 5'(count_r);
              out_nxt.last       = 1'b1;
            end else begin
              out_nxt.kind = vae_pkg::KIND_NONE;
            end
            pend_vld_nxt = 1'b0;
          end
          default: begin
            out_nxt.kind = vae_pkg::KIND_NONE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      proc_vld_r  <= 1'b0;
      used_r      <= '0;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
      attack_r    <= vae_pkg::ATTACK_STEP_RST;
      damper_r    <= vae_pkg::DAMP_COEF_RST;
      vcount_r    <= vae_pkg::VOICE_LIM_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      proc_vld_r  <= proc_vld_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      attack_r    <= attack_nxt;
      damper_r    <= damper_nxt;
      vcount_r    <= vcount_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    proc_idx_r  <= proc_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_level_r <= hit_level_nxt;
    free_idx_r  <= free_idx_nxt;
    min_idx_r   <= min_idx_nxt;
    min_level_r <= min_level_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

`ifndef SYNTH
  // live count tracks the used bits
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(used_r)))
    else $error("live count differs from used slots");

  // write-back never hits the entry being read in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("slot memory read and write collide");

  // the final result of a transaction never overlaps slot processing
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> !proc_vld_r)
    else $error("last result while a slot is still in process");

  // only tick reports come without the last mark
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (out_r.kind == vae_pkg::KIND_LIVE))
    else $error("non-final result that is not a live report");

  // a held report exists only while a tick walks
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (cmd_r.op == vae_pkg::OP_TICK && state_r != ST_IDLE))
    else $error("held report outside a tick");
`endif

endmodule

// File: verif/voice_slot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_slot_checker
// Watches the command, result and register ports of the voice allocator.
// Every accepted command transaction is replayed on a private slot table,
// and each result transaction is compared field by field with the oldest
// predicted report.
// ----------------------------------------------------------------------------
module voice_slot_checker #(
  parameter int SLOTS = vae_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  vae_pkg::in_t              in_data,
  input  logic                      out_valid,
  input  vae_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [vae_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        outstanding,
  output int                        reports_checked
);

  // private copy of the slot table and registers
  logic          used [SLOTS];
  vae_pkg::rec_t slot_rec [SLOTS];
  logic [14:0]   attack_step;
  logic [14:0]   damp_coef;
  logic [8:0]    voice_lim;

  // predicted reports, oldest first
  vae_pkg::out_t due_reports[$];
  int            mismatches = 0;
  int            seen = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("report %0d field %s: got %0d, expected %0d",
                                seen, name, got, want));
  endtask

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += used[i] ? 1 : 0;
    return n;
  endfunction

  // Q15 multiply, truncating
  function automatic int scaled(input int lv, input int coef);
    return (lv * coef) >> 15;
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      used[i]     = 1'b0;
      slot_rec[i] = '0;
    end
  endtask

  // Advance the slot table by one command and queue the reports it causes
  task automatic apply_command(input vae_pkg::in_t cmd);
    vae_pkg::out_t r;
    int            pick;
    int            nrep;
    int            lv;
    logic          again;
    logic [7:0]    v;
    r = '0;
    case (cmd.op)
      vae_pkg::OP_NOTE_ON: begin
        if (cmd.note < vae_pkg::NOTE_LOW || cmd.note > vae_pkg::NOTE_HIGH) begin
          r.kind       = vae_pkg::KIND_REJECT;
          r.note_res   = cmd.note;
          r.live_count = 5'(live_slots());
          r.last       = 1'b1;
          due_reports.push_back(r);
        end else begin
          v     = ({1'b0, cmd.voice} >= voice_lim) ? 8'd0 : cmd.voice;
          pick  = -1;
          again = 1'b0;
          // retrigger a matching slot, else take a free one, else steal
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && used[i] && slot_rec[i].note == cmd.note &&
                slot_rec[i].voice == v && slot_rec[i].channel == cmd.channel) begin
              pick  = i;
              again = 1'b1;
            end
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && !used[i]) pick = i;
          if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < SLOTS; i++)
              if (slot_rec[i].level < slot_rec[pick].level) pick = i;
          end
          used[pick]               = 1'b1;
          slot_rec[pick].note      = cmd.note;
          slot_rec[pick].voice     = v;
          slot_rec[pick].channel   = cmd.channel;
          slot_rec[pick].velocity  = cmd.velocity;
          slot_rec[pick].stage     = vae_pkg::STG_ATTACK;
          slot_rec[pick].end_time  = cmd.end_time;
          slot_rec[pick].sustained = cmd.is_sustained;
          slot_rec[pick].drum      = cmd.is_drum;
          slot_rec[pick].decay     = cmd.decay_coef;
          if (!again) slot_rec[pick].level = '0;
          r.kind         = vae_pkg::KIND_PLACED;
          r.slot         = 4'(pick);
          r.note_res     = cmd.note;
          r.voice_res    = v;
          r.level        = slot_rec[pick].level;
          r.velocity_res = cmd.velocity;
          r.live_count   = 5'(live_slots());
          r.last         = 1'b1;
          due_reports.push_back(r);
        end
      end
      vae_pkg::OP_NOTE_OFF: begin
        // release held slots of this note and channel
        for (int i = 0; i < SLOTS; i++)
          if (used[i] && slot_rec[i].note == cmd.note &&
              slot_rec[i].channel == cmd.channel &&
              slot_rec[i].stage == vae_pkg::STG_HELD)
            slot_rec[i].stage = vae_pkg::STG_RELEASED;
        r.kind       = vae_pkg::KIND_OFF_DONE;
        r.note_res   = cmd.note;
        r.live_count = 5'(live_slots());
        r.last       = 1'b1;
        due_reports.push_back(r);
      end
      vae_pkg::OP_ALL_OFF: begin
        clear_slots();
        r.kind = vae_pkg::KIND_NONE;
        r.last = 1'b1;
        due_reports.push_back(r);
      end
      default: begin
        // tick: step each live envelope in slot order
        nrep = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!used[i]) continue;
          lv = int'(slot_rec[i].level);
          case (slot_rec[i].stage)
            vae_pkg::STG_ATTACK: begin
              lv += int'(attack_step);
              if (lv >= int'(vae_pkg::LEVEL_MAX)) begin
                lv                = int'(vae_pkg::LEVEL_MAX);
                slot_rec[i].stage = vae_pkg::STG_HELD;
              end
            end
            vae_pkg::STG_HELD: begin
              if (!slot_rec[i].sustained) lv = scaled(lv, int'(slot_rec[i].decay));
              if (cmd.now_time >= slot_rec[i].end_time && !slot_rec[i].drum)
                slot_rec[i].stage = vae_pkg::STG_RELEASED;
            end
            vae_pkg::STG_RELEASED: begin
              lv = scaled(lv, slot_rec[i].sustained ? int'(slot_rec[i].decay)
                                                    : int'(damp_coef));
            end
            default: ;
          endcase
          slot_rec[i].level = 15'(lv);
          if (lv < int'(vae_pkg::LEVEL_FLOOR)) begin
            used[i] = 1'b0;
          end else begin
            r              = '0;
            r.kind         = vae_pkg::KIND_LIVE;
            r.slot         = 4'(i);
            r.note_res     = slot_rec[i].note;
            r.voice_res    = slot_rec[i].voice;
            r.level        = 15'(lv);
            r.velocity_res = slot_rec[i].velocity;
            due_reports.push_back(r);
            nrep++;
          end
        end
        if (nrep == 0) begin
          r      = '0;
          r.kind = vae_pkg::KIND_NONE;
          r.last = 1'b1;
          due_reports.push_back(r);
        end else begin
          // the final report carries the count
          r            = due_reports.pop_back();
          r.live_count = 5'(nrep);
          r.last       = 1'b1;
          due_reports.push_back(r);
        end
      end
    endcase
  endtask

  task automatic check_report(input vae_pkg::out_t got);
    vae_pkg::out_t want;
    if (due_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected report kind %0d slot %0d level %0d",
                                got.kind, got.slot, got.level));
      return;
    end
    want = due_reports.pop_front();
    compare_field("kind", int'(got.kind), int'(want.kind));
    compare_field("slot", int'(got.slot), int'(want.slot));
    compare_field("note_res", int'(got.note_res), int'(want.note_res));
    compare_field("voice_res", int'(got.voice_res), int'(want.voice_res));
    compare_field("level", int'(got.level), int'(want.level));
    compare_field("velocity_res", int'(got.velocity_res), int'(want.velocity_res));
    compare_field("live_count", int'(got.live_count), int'(want.live_count));
    compare_field("last", int'(got.last), int'(want.last));
    seen++;
  endtask

  // Check results first: a result at an accept edge belongs to older work
  always @(posedge clk) begin
    if (!rst_n) begin
      attack_step = vae_pkg::ATTACK_STEP_RST;
      damp_coef   = vae_pkg::DAMP_COEF_RST;
      voice_lim   = vae_pkg::VOICE_LIM_RST;
      clear_slots();
      due_reports.delete();
    end else begin
      if (out_valid) check_report(out_data);
      if (cfg_we) begin
        case (cfg_index)
          vae_pkg::CFG_ATTACK_STEP: attack_step = cfg_wdata[14:0];
          vae_pkg::CFG_DAMP_COEF:   damp_coef   = cfg_wdata[14:0];
          vae_pkg::CFG_VOICE_LIM:   voice_lim   = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (start && !busy) apply_command(in_data);
    end
    fail_count      <= mismatches;
    outstanding     <= due_reports.size();
    reports_checked <= seen;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the voice allocator testbench. Drives a directed pass over the
// note range limits, retrigger, release, drum and damper cases, then random
// note on, note off, tick and clear traffic under several register settings
// with random sender gaps. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;

  localparam int         SLOTS       = vae_pkg::SLOTS_DEF;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_ITEMS = 100;
  localparam int         PHASES      = 5;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  vae_pkg::in_t              in_data   = '0;
  logic                      cfg_we    = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [vae_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                      busy;
  logic                      out_valid;
  vae_pkg::out_t             out_data;

  int          fail_count;
  int          outstanding;
  int          reports_checked;
  int          cycles   = 0;
  int          idle_pct = 0;
  int          settings = 0;
  int          op_count [4] = '{0, 0, 0, 0};
  int unsigned now_ms   = 0;

  always #10 clk = ~clk;

  voice_allocator_envelope #(.SLOTS(SLOTS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  voice_slot_checker #(.SLOTS(SLOTS)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .reports_checked (reports_checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic vae_pkg::in_t mk(input logic [1:0] op, input logic [6:0] note,
                                      input logic [3:0] ch, input logic [6:0] vel,
                                      input logic [7:0] voice, input logic sus,
                                      input logic drum, input logic [14:0] dec,
                                      input logic [31:0] endt, input logic [31:0] nowt);
    vae_pkg::in_t c;
    c.op           = op;
    c.note         = note;
    c.channel      = ch;
    c.velocity     = vel;
    c.voice        = voice;
    c.is_sustained = sus;
    c.is_drum      = drum;
    c.decay_coef   = dec;
    c.end_time     = endt;
    c.now_time     = nowt;
    return c;
  endfunction

  // Mostly well-formed traffic on a small note pool so notes retrigger,
  // release and get stolen; a few commands stay fully random
  function automatic vae_pkg::in_t next_command();
    vae_pkg::in_t c;
    int           pick;
    int           r;
    c.op           = 2'($urandom_range(0, 3));
    c.note         = 7'($urandom_range(0, 127));
    c.channel      = 4'($urandom_range(0, 15));
    c.velocity     = 7'($urandom_range(0, 127));
    c.voice        = 8'($urandom_range(0, 255));
    c.is_sustained = 1'($urandom_range(0, 1));
    c.is_drum      = 1'($urandom_range(0, 1));
    c.decay_coef   = 15'($urandom_range(0, 32767));
    c.end_time     = $urandom;
    c.now_time     = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) return c;
    if ($urandom_range(0, 4) != 0) c.channel = 4'($urandom_range(0, 1));
    c.note = 7'($urandom_range(40, 59));
    if (pick < 60) begin
      c.op = vae_pkg::OP_NOTE_ON;
      r = $urandom_range(0, 19);
      if (r == 0) c.note = 7'($urandom_range(0, 127));
      else if (r < 3) c.note = 7'($urandom_range(vae_pkg::NOTE_LOW, vae_pkg::NOTE_HIGH));
      if ($urandom_range(0, 3) != 0) c.voice = 8'($urandom_range(0, 1));
      c.is_drum = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) c.decay_coef = 15'($urandom_range(28000, 32767));
      if ($urandom_range(0, 19) != 0) c.end_time = now_ms + $urandom_range(0, 400);
    end else if (pick < 78) begin
      c.op = vae_pkg::OP_TICK;
      now_ms += $urandom_range(0, 40);
      if ($urandom_range(0, 19) != 0) c.now_time = now_ms;
    end else if (pick < 98) begin
      c.op = vae_pkg::OP_NOTE_OFF;
    end else begin
      c.op = vae_pkg::OP_ALL_OFF;
    end
    return c;
  endfunction

  // Present one command transaction, hold it until accepted
  task automatic send(input vae_pkg::in_t t);
    // idle the sender in about idle_pct of the cycles it could present
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= t;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_count[t.op]++;
  endtask

  // Drop start and wait until every predicted report is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // Write all registers back to back; the spare index must change nothing
  task automatic set_config(input logic [14:0] atk, input logic [14:0] dmp,
                            input logic [8:0] vc);
    cfg_we    <= 1'b1;
    cfg_index <= vae_pkg::CFG_ATTACK_STEP;
    cfg_wdata <= atk;
    @(posedge clk);
    cfg_index <= vae_pkg::CFG_DAMP_COEF;
    cfg_wdata <= dmp;
    @(posedge clk);
    cfg_index <= vae_pkg::CFG_VOICE_LIM;
    cfg_wdata <= vae_pkg::CFG_W'(vc);
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= vae_pkg::CFG_W'($urandom_range(0, 32767));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty tick, range limits, voice remap, slot dies in attack
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd0));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd0));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd127, 4'd15, 7'd127, 8'd255, 1'b1, 1'b1, 15'd32767,
            32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd20, 4'd1, 7'd5, 8'd3, 1'b0, 1'b0, 15'd100,
            32'd0, 32'd0));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd109, 4'd1, 7'd5, 8'd3, 1'b0, 1'b0, 15'd100,
            32'd0, 32'd0));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd21, 4'd0, 7'd127, 8'd255, 1'b0, 1'b0, 15'd32767,
            32'd0, 32'd0));
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd0));
    drain();

    // full attack step, zero damper, all voices valid
    set_config(15'd32767, 15'd0, 9'd256);
    send(mk(vae_pkg::OP_NOTE_ON, 7'd108, 4'd15, 7'd0, 8'd255, 1'b1, 1'b1, 15'd0,
            32'hFFFF_FFFF, 32'd0));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd60, 4'd3, 7'd64, 8'd7, 1'b0, 1'b0, 15'd32000,
            32'd100, 32'd0));
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd0));
    // retrigger keeps the level
    send(mk(vae_pkg::OP_NOTE_ON, 7'd108, 4'd15, 7'd9, 8'd255, 1'b1, 1'b1, 15'd0,
            32'hFFFF_FFFF, 32'd0));
    send(mk(vae_pkg::OP_NOTE_OFF, 7'd60, 4'd3, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0,
            32'd0, 32'd0));
    // released non-sustained note falls through the damper
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd50));
    send(mk(vae_pkg::OP_NOTE_ON, 7'd60, 4'd3, 7'd1, 8'd7, 1'b0, 1'b1, 15'd30000,
            32'd10, 32'd0));
    // drums ignore the end time
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0,
            32'hFFFF_FFFF));
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0,
            32'hFFFF_FFFF));
    // released sustained note decays by its own coefficient
    send(mk(vae_pkg::OP_NOTE_OFF, 7'd108, 4'd15, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0,
            32'd0, 32'd0));
    send(mk(vae_pkg::OP_TICK, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0, 32'd0, 32'd0));
    send(mk(vae_pkg::OP_ALL_OFF, 7'd0, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0,
            32'd0, 32'd0));
    send(mk(vae_pkg::OP_NOTE_OFF, 7'd50, 4'd0, 7'd0, 8'd0, 1'b0, 1'b0, 15'd0,
            32'd0, 32'd0));

    // random traffic, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_config(15'd8000, vae_pkg::DAMP_COEF_RST, vae_pkg::VOICE_LIM_RST);
        1: set_config(15'd1, 15'd32767, 9'd1);
        2: set_config(15'd32767, 15'd0, 9'd256);
        default: set_config(15'($urandom_range(98, 12000)), 15'($urandom_range(0, 32767)),
                            9'($urandom_range(1, 256)));
      endcase
      idle_pct = (p < 2) ? 15 : (p < 4) ? 55 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once mid-phase until all reports are back
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        send(next_command());
      end
    end

    drain();
    repeat (SLOTS + 8) @(posedge clk);

    $display("ran %0d note on, %0d note off, %0d tick and %0d all-off transactions",
             op_count[vae_pkg::OP_NOTE_ON], op_count[vae_pkg::OP_NOTE_OFF],
             op_count[vae_pkg::OP_TICK], op_count[vae_pkg::OP_ALL_OFF]);
    $display("checked %0d result transactions over %0d register settings",
             reports_checked, settings);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
